FILE: design/cki_pkg.sv
// ----------------------------------------------------------------------------
// cki_pkg
// shared types and constants for the collatz k-th iterate block
// ----------------------------------------------------------------------------
package cki_pkg;

  localparam int unsigned VALUE_W = 64;

  // smallest odd value whose 3n+1 no longer fits in 64 bits
  localparam logic [VALUE_W-1:0] OVF_LIMIT = 64'h5555_5555_5555_5555;

  typedef struct packed {
    logic [VALUE_W-1:0] start_value;
    logic [VALUE_W-1:0] step_count;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] end_value;
    logic               overflowed;
  } result_t;

  typedef struct packed {
    logic load;
    logic fold;
    logic step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic fold_done;
    logic finish;
  } status_t;

endpackage

FILE: design/cki_datapath.sv
// ----------------------------------------------------------------------------
// cki_datapath
// orbit value, step counter, residue of the step count mod 3, result register
// ----------------------------------------------------------------------------
module cki_datapath (
  input  logic             clk,
  input  cki_pkg::item_t   item,
  input  cki_pkg::cmd_t    cmd,
  output cki_pkg::status_t status,
  output cki_pkg::result_t result
);

  logic [cki_pkg::VALUE_W-1:0] n;
  logic [cki_pkg::VALUE_W-1:0] k;
  logic [cki_pkg::VALUE_W-1:0] f;

  logic [cki_pkg::VALUE_W-1:0] n_next;
  logic [cki_pkg::VALUE_W-1:0] f_next;
  logic [1:0]                  res_dec;
  logic [1:0]                  res;
  logic                        k_zero;
  logic                        n_zero;
  logic                        n_one;
  logic                        n_odd;
  logic                        over;
  cki_pkg::result_t            result_next;

  assign k_zero = (k == '0);
  assign n_zero = (n == '0);
  assign n_one  = (n == cki_pkg::VALUE_W'(1));
  assign n_odd  = n[0];
  assign over   = (n >= cki_pkg::OVF_LIMIT);

  // 4 is 1 mod 3, so dropping two low bits into the sum keeps the residue
  assign f_next = (f >> 2) + {{(cki_pkg::VALUE_W-2){1'b0}}, f[1:0]};

  // residue once folded below 4: code 3 means 0
  assign res     = (f[1:0] == 2'd3) ? 2'd0 : f[1:0];
  assign res_dec = (res == 2'd0) ? 2'd2 : (res - 2'd1);

  assign n_next = n_odd ? ((n << 1) + n + cki_pkg::VALUE_W'(1)) : (n >> 1);

  assign status.fold_done = (f[cki_pkg::VALUE_W-1:2] == '0);
  assign status.finish    = k_zero | n_zero | n_one | (n_odd & over);

  always_comb begin
    result_next.end_value  = n;
    result_next.overflowed = 1'b0;
    if (k_zero || n_zero) begin
      result_next.end_value = n;
    end else if (n_one) begin
      case (res)
        2'd0:    result_next.end_value = cki_pkg::VALUE_W'(1);
        2'd1:    result_next.end_value = cki_pkg::VALUE_W'(4);
        default: result_next.end_value = cki_pkg::VALUE_W'(2);
      endcase
    end else begin
      result_next.end_value  = '0;
      result_next.overflowed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= item.start_value;
      k <= item.step_count;
      f <= item.step_count;
    end
    if (cmd.fold) begin
      f <= f_next;
    end
    if (cmd.step) begin
      n <= n_next;
      k <= k - cki_pkg::VALUE_W'(1);
      f <= {{(cki_pkg::VALUE_W-2){1'b0}}, res_dec};
    end
    if (cmd.capture) begin
      result <= result_next;
    end
  end

endmodule

FILE: design/cki_controller.sv
// ----------------------------------------------------------------------------
// cki_controller
// sequencer for load, residue fold and map steps, result beat valid
// ----------------------------------------------------------------------------
module cki_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  cki_pkg::status_t status,
  output cki_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FOLD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign item_ready = (state == ST_IDLE);
  assign slot_free  = !result_valid || result_ready;

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.fold    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (status.fold_done) begin
          state_next = ST_RUN;
        end else begin
          cmd.fold = 1'b1;
        end
      end
      ST_RUN: begin
        if (!status.finish) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.fold, cmd.step, cmd.capture}) <= 1)
    else $error("more than one datapath command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!result_valid || result_ready))
    else $error("result overwritten before its beat");

  a_capture_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> result_valid)
    else $error("captured result not offered");

  a_step_not_done: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (state == ST_RUN) && !status.finish)
    else $error("step issued outside an active orbit");
`endif

endmodule

FILE: design/collatz_kth_iterate.sv
// ----------------------------------------------------------------------------
// collatz_kth_iterate
// value after a given number of collatz map steps, with 64-bit overflow flag
// ----------------------------------------------------------------------------
// sequence: a load, residue folds of step_count (two bits per fold) until it
//   is below 4, a move to the run state, then map steps until the count runs
//   out, the value hits 0 or 1, or overflow, then a capture
// throughput: one item at a time, the next accepted the cycle after capture;
//   capture holds while a result waits, and no new item is taken meanwhile
// reset: synchronous active-high rst idles the sequencer and drops result_valid
// ----------------------------------------------------------------------------
module collatz_kth_iterate (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  cki_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output cki_pkg::result_t result
);

  cki_pkg::cmd_t    cmd;
  cki_pkg::status_t status;

  cki_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  cki_datapath u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
